>>> sv/vertical_swipe_page_switcher_core_assert.svh
`ifndef VERTICAL_SWIPE_PAGE_SWITCHER_CORE_ASSERT_SVH
`define VERTICAL_SWIPE_PAGE_SWITCHER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define VSPS_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define VSPS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> sv/vsps_pkg.sv
package vsps_pkg;

  localparam int CFG_BITS    = 12;
  localparam int OFFSET_BITS = 13;

  localparam logic [1:0] CMD_PRESS   = 2'd0;
  localparam logic [1:0] CMD_DRAG    = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  localparam logic [1:0] PAGE_HOME     = 2'd0;
  localparam logic [1:0] PAGE_NOTIF    = 2'd1;
  localparam logic [1:0] PAGE_OVERVIEW = 2'd2;

  localparam logic [1:0] ANIM_NONE    = 2'd0;
  localparam logic [1:0] ANIM_SNAP    = 2'd1;
  localparam logic [1:0] ANIM_REBOUND = 2'd2;

  localparam logic [1:0] REG_SWIPE_THRESHOLD   = 2'd0;
  localparam logic [1:0] REG_MAX_DRAG          = 2'd1;
  localparam logic [1:0] REG_MIN_VERTICAL_DRAG = 2'd2;

  localparam logic [CFG_BITS-1:0] SWIPE_THRESHOLD_RESET   = 12'd82;
  localparam logic [CFG_BITS-1:0] MAX_DRAG_RESET          = 12'd412;
  localparam logic [CFG_BITS-1:0] MIN_VERTICAL_DRAG_RESET = 12'd6;

  typedef struct packed {
    logic [CFG_BITS-1:0] swipe_threshold;
    logic [CFG_BITS-1:0] max_drag;
    logic [CFG_BITS-1:0] min_vertical_drag;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                    page_now;
    logic [1:0]                    page_aimed;
    logic [1:0]                    page_shown;
    logic [1:0]                    motion_kind;
    logic signed [OFFSET_BITS-1:0] offset_out;
    logic                          is_dragging;
    logic                          is_pressed;
  } result_t;

endpackage

>>> sv/vsps_cfg_regs.sv
module vsps_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [vsps_pkg::CFG_BITS-1:0] cfg_data,
  output vsps_pkg::cfg_t                cfg
);
  import vsps_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.swipe_threshold   <= SWIPE_THRESHOLD_RESET;
      cfg.max_drag          <= MAX_DRAG_RESET;
      cfg.min_vertical_drag <= MIN_VERTICAL_DRAG_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SWIPE_THRESHOLD:   cfg.swipe_threshold   <= cfg_data;
        REG_MAX_DRAG:          cfg.max_drag          <= cfg_data;
        REG_MIN_VERTICAL_DRAG: cfg.min_vertical_drag <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

>>> sv/vsps_gesture.sv
`include "vertical_swipe_page_switcher_core_assert.svh"

module vsps_gesture #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [1:0]            cmd,
  input  logic [COORD_BITS-1:0] x,
  input  logic [COORD_BITS-1:0] y,
  input  vsps_pkg::cfg_t        cfg,
  output vsps_pkg::result_t     res
);
  import vsps_pkg::*;

  localparam int MW = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 1;

  logic [1:0]                    committed_page, committed_page_next;
  logic [1:0]                    aimed_page, aimed_page_next;
  logic [1:0]                    animation_kind, animation_kind_next;
  logic [COORD_BITS-1:0]         origin_x, origin_x_next;
  logic [COORD_BITS-1:0]         origin_y, origin_y_next;
  logic signed [OFFSET_BITS-1:0] drag_offset, drag_offset_next;
  logic                          touch_held, touch_held_next;
  logic                          drag_active, drag_active_next;

  logic signed [COORD_BITS:0] dx, dy, neg_dx, neg_dy;
  logic [COORD_BITS-1:0]      adx, ady;
  logic [MW-1:0]              adx_w, ady_w, mvd_w;
  logic signed [MW-1:0]       dy_w, lim_w, neg_lim_w, dy_clamped;
  logic                       vertical;
  logic [1:0]                 dir_page;
  logic [CFG_BITS-1:0]        offset_mag;
  logic signed [OFFSET_BITS-1:0] neg_offset;

  always_comb begin
    dx     = $signed({1'b0, x}) - $signed({1'b0, origin_x});
    dy     = $signed({1'b0, y}) - $signed({1'b0, origin_y});
    neg_dx = -dx;
    neg_dy = -dy;
    adx    = dx[COORD_BITS] ? neg_dx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    ady    = dy[COORD_BITS] ? neg_dy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    adx_w  = MW'(adx);
    ady_w  = MW'(ady);
    mvd_w  = MW'(cfg.min_vertical_drag);
    vertical = (ady_w >= mvd_w) && (adx_w <= ady_w);

    dy_w      = MW'(dy);
    lim_w     = $signed(MW'(cfg.max_drag));
    neg_lim_w = -lim_w;
    if (dy_w > lim_w) begin
      dy_clamped = lim_w;
    end else if (dy_w < neg_lim_w) begin
      dy_clamped = neg_lim_w;
    end else begin
      dy_clamped = dy_w;
    end

    if (dy[COORD_BITS]) begin
      dir_page = (committed_page == PAGE_NOTIF) ? PAGE_HOME : PAGE_OVERVIEW;
    end else if (dy != '0) begin
      dir_page = (committed_page == PAGE_OVERVIEW) ? PAGE_HOME : PAGE_NOTIF;
    end else begin
      dir_page = committed_page;
    end

    neg_offset = -drag_offset;
    offset_mag = drag_offset[OFFSET_BITS-1] ? neg_offset[CFG_BITS-1:0]
                                            : drag_offset[CFG_BITS-1:0];
  end

  always_comb begin
    committed_page_next = committed_page;
    aimed_page_next     = aimed_page;
    animation_kind_next = animation_kind;
    origin_x_next       = origin_x;
    origin_y_next       = origin_y;
    drag_offset_next    = drag_offset;
    touch_held_next     = touch_held;
    drag_active_next    = drag_active;
    case (cmd)
      CMD_PRESS: begin
        origin_x_next       = x;
        origin_y_next       = y;
        aimed_page_next     = committed_page;
        animation_kind_next = ANIM_NONE;
        drag_offset_next    = '0;
        touch_held_next     = 1'b1;
        drag_active_next    = 1'b0;
      end
      CMD_DRAG: begin
        if (touch_held) begin
          if (vertical) begin
            drag_active_next = 1'b1;
            aimed_page_next  = dir_page;
            drag_offset_next = dy_clamped[OFFSET_BITS-1:0];
          end else begin
            drag_active_next = 1'b0;
            aimed_page_next  = committed_page;
            drag_offset_next = '0;
          end
        end
      end
      CMD_RELEASE: begin
        if (touch_held) begin
          if (drag_active && (offset_mag >= cfg.swipe_threshold)) begin
            committed_page_next = aimed_page;
            animation_kind_next = ANIM_SNAP;
          end else begin
            aimed_page_next     = committed_page;
            animation_kind_next = drag_active ? ANIM_REBOUND : ANIM_NONE;
          end
          drag_offset_next = '0;
          touch_held_next  = 1'b0;
          drag_active_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.page_now    = committed_page_next;
    res.page_aimed  = aimed_page_next;
    if (drag_active_next && (aimed_page_next != PAGE_HOME)) begin
      res.page_shown = aimed_page_next;
    end else begin
      res.page_shown = committed_page_next;
    end
    res.motion_kind = animation_kind_next;
    res.offset_out  = drag_offset_next;
    res.is_dragging = drag_active_next;
    res.is_pressed  = touch_held_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      committed_page <= PAGE_HOME;
      aimed_page     <= PAGE_HOME;
      animation_kind <= ANIM_NONE;
      origin_x       <= '0;
      origin_y       <= '0;
      drag_offset    <= '0;
      touch_held     <= 1'b0;
      drag_active    <= 1'b0;
    end else if (fire) begin
      committed_page <= committed_page_next;
      aimed_page     <= aimed_page_next;
      animation_kind <= animation_kind_next;
      origin_x       <= origin_x_next;
      origin_y       <= origin_y_next;
      drag_offset    <= drag_offset_next;
      touch_held     <= touch_held_next;
      drag_active    <= drag_active_next;
    end
  end

  `VSPS_ASSERT_IMPLIES(a_drag_needs_press, clk, rst, drag_active, touch_held)
  `VSPS_ASSERT_IMPLIES(a_idle_offset_zero, clk, rst, !drag_active, drag_offset == '0)

endmodule

>>> sv/vsps_out_fifo.sv
`include "vertical_swipe_page_switcher_core_assert.svh"

module vsps_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  vsps_pkg::result_t push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_stall,
  output vsps_pkg::result_t head
);
  import vsps_pkg::*;

  result_t    entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count, count_next;
  logic       pop;

  always_comb begin
    space     = (count != 2'd2);
    out_valid = (count != 2'd0);
    pop       = out_valid && !out_stall;
    head      = entry[rd_ptr];
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  `VSPS_ASSERT_IMPLIES(a_no_overflow, clk, rst, push, count != 2'd2)
  `VSPS_ASSERT_NEXT(a_pop_drains, clk, rst, pop && !push, (count + 2'd1) == $past(count))

endmodule

>>> sv/vertical_swipe_page_switcher_core.sv
// Channel | Handshake             | Payload
// --------+-----------------------+------------------------------------------
// input   | in_valid / in_stall   | cmd, touch_x, touch_y
// output  | out_valid / out_stall | seven result fields, page_now to is_pressed
// config  | cfg_write             | cfg_index, cfg_data
//
// One event per cycle is sustained while out_stall stays low; a result passes through the input
// register, then the gesture update into the result queue, before it reaches the outputs.
// Reset is synchronous and restores the register defaults and the idle gesture state.
// A two-entry result queue keeps input transfers going while a result waits.
// in_stall rises only when the input register is full and the queue has no room.
module vertical_swipe_page_switcher_core #(
  parameter int COORD_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       cmd,
  input  logic [COORD_BITS-1:0]            touch_x,
  input  logic [COORD_BITS-1:0]            touch_y,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       page_now,
  output logic [1:0]                       page_aimed,
  output logic [1:0]                       page_shown,
  output logic [1:0]                       motion_kind,
  output logic signed [vsps_pkg::OFFSET_BITS-1:0] offset_out,
  output logic                             is_dragging,
  output logic                             is_pressed,
  input  logic                             cfg_write,
  input  logic [1:0]                       cfg_index,
  input  logic [vsps_pkg::CFG_BITS-1:0]    cfg_data
);
  import vsps_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t head;

  logic                  s1_valid, s1_valid_next;
  logic [1:0]            s1_cmd;
  logic [COORD_BITS-1:0] s1_x;
  logic [COORD_BITS-1:0] s1_y;
  logic                  space;
  logic                  fire;
  logic                  in_take;

  always_comb begin
    fire          = s1_valid && space;
    in_stall      = s1_valid && !space;
    in_take       = in_valid && !in_stall;
    s1_valid_next = in_take || (s1_valid && !fire);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd <= cmd;
      s1_x   <= touch_x;
      s1_y   <= touch_y;
    end
  end

  vsps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vsps_gesture #(
    .COORD_BITS (COORD_BITS)
  ) u_gesture (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .cmd  (s1_cmd),
    .x    (s1_x),
    .y    (s1_y),
    .cfg  (cfg),
    .res  (res)
  );

  vsps_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign page_now    = head.page_now;
  assign page_aimed  = head.page_aimed;
  assign page_shown  = head.page_shown;
  assign motion_kind = head.motion_kind;
  assign offset_out  = head.offset_out;
  assign is_dragging = head.is_dragging;
  assign is_pressed  = head.is_pressed;

endmodule
